>>> sv/mtg_pkg.sv
// mtg_pkg: constants, types and functions shared by the twister generator
// no dependencies
package mtg_pkg;

	localparam int unsigned TABLE_WORDS = 624;
	localparam int unsigned SHIFT_OFFSET = 397;
	localparam int unsigned ADDR_W = $clog2(TABLE_WORDS);
	localparam int unsigned WORD_W = 32;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] RESET_SEED = 32'd5489;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc60000;
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_WORDS - 1);

	typedef enum logic [1:0] {
		ST_FILL,
		ST_PRIME,
		ST_RUN
	} gen_state_t;

	// index plus offset, wrapped once into the table
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] idx,
			input logic [ADDR_W:0] offs);
		logic [ADDR_W:0] sum;
		sum = {1'b0, idx} + offs;
		if (sum >= (ADDR_W+1)'(TABLE_WORDS)) begin
			sum = sum - (ADDR_W+1)'(TABLE_WORDS);
		end
		return sum[ADDR_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
		logic [WORD_W-1:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

>>> sv/mtg_ram.sv
// mtg_ram: generic single-write, single-read ram with registered read data
// no dependencies
module mtg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/mtg_front.sv
// mtg_front: takes draw requests and keeps a count of pending words
// depends on mtg_pkg
module mtg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic draw_valid,
	output logic draw_ready,
	input  logic draw,
	output logic pend,
	input  logic take
);

	logic [mtg_pkg::CNT_W-1:0] cnt_q;
	logic                      acc;

	assign draw_ready = (cnt_q < mtg_pkg::CNT_W'(mtg_pkg::QUEUE_DEPTH));
	// a transfer with draw low asks for nothing
	assign acc = draw_valid && draw_ready && draw;
	assign pend = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc && !take) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (!acc && take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_take_pend: assert property (@(posedge clk) disable iff (!arst_n) take |-> pend)
		else $error("word taken with no pending request");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mtg_pkg::CNT_W'(mtg_pkg::QUEUE_DEPTH))
		else $error("request count overflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !take) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("request count missed a transfer");

endmodule

>>> sv/mtg_back.sv
// mtg_back: table fill, per-word in-place twist, tempering and output register
// depends on mtg_pkg and mtg_ram
module mtg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_we,
	input  logic [mtg_pkg::WORD_W-1:0]  seed_wdata,
	input  logic                        pend,
	output logic                        take,
	output logic                        value_valid,
	input  logic                        value_ready,
	output logic [mtg_pkg::WORD_W-1:0]  value
);

	localparam int unsigned AW = mtg_pkg::ADDR_W;
	localparam int unsigned WW = mtg_pkg::WORD_W;

	mtg_pkg::gen_state_t state_q, state_d;
	logic [AW-1:0] k_q, ptr_q;
	logic [WW-1:0] prev_q, cur_q, val_q;
	logic          ovalid_q;
	logic [WW-1:0] fill_word, nxt_word, far_word, mix, fresh;
	logic [WW-1:0] prod;
	logic          we;
	logic [AW-1:0] waddr, raddr_n, raddr_f;
	logic [WW-1:0] wdata;
	logic          fire;

	assign prod = WW'(mtg_pkg::INIT_MULT * (prev_q ^ (prev_q >> 30)));
	assign fill_word = (k_q == '0) ? prev_q : prod + WW'(k_q);

	assign fire = (state_q == mtg_pkg::ST_RUN) && pend && (!ovalid_q || value_ready);
	assign take = fire;

	assign mix = {cur_q[WW-1], nxt_word[WW-2:0]};
	assign fresh = far_word ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_MATRIX : '0);

	always_comb begin
		we = 1'b0;
		waddr = k_q;
		wdata = fill_word;
		raddr_n = mtg_pkg::wrap_add(ptr_q, (AW+1)'(1));
		raddr_f = mtg_pkg::wrap_add(ptr_q, (AW+1)'(mtg_pkg::SHIFT_OFFSET));
		state_d = state_q;
		unique case (state_q)
			mtg_pkg::ST_FILL: begin
				we = 1'b1;
				if (k_q == mtg_pkg::LAST_IDX) begin
					state_d = mtg_pkg::ST_PRIME;
				end
			end
			mtg_pkg::ST_PRIME: begin
				state_d = mtg_pkg::ST_RUN;
			end
			mtg_pkg::ST_RUN: begin
				if (fire) begin
					we = 1'b1;
					waddr = ptr_q;
					wdata = fresh;
					raddr_n = mtg_pkg::wrap_add(ptr_q, (AW+1)'(2));
					raddr_f = mtg_pkg::wrap_add(ptr_q, (AW+1)'(mtg_pkg::SHIFT_OFFSET + 1));
				end
			end
			default: begin
				state_d = mtg_pkg::ST_FILL;
			end
		endcase
	end

	// two copies of the table give the two reads per word
	mtg_ram #(.WIDTH(WW), .DEPTH(mtg_pkg::TABLE_WORDS)) u_ram_nxt (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr_n), .rdata(nxt_word)
	);
	mtg_ram #(.WIDTH(WW), .DEPTH(mtg_pkg::TABLE_WORDS)) u_ram_far (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr_f), .rdata(far_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtg_pkg::ST_FILL;
		end else if (seed_we) begin
			state_q <= mtg_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			ptr_q <= '0;
			prev_q <= mtg_pkg::RESET_SEED;
			ovalid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				k_q <= '0;
				ptr_q <= '0;
				prev_q <= seed_wdata;
			end else if (state_q == mtg_pkg::ST_FILL) begin
				k_q <= k_q + 1'b1;
				prev_q <= fill_word;
			end else if (fire) begin
				ptr_q <= (ptr_q == mtg_pkg::LAST_IDX) ? '0 : ptr_q + 1'b1;
			end
			if (fire) begin
				ovalid_q <= 1'b1;
			end else if (value_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mtg_pkg::ST_FILL && k_q == '0) begin
			cur_q <= prev_q;
		end else if (fire) begin
			cur_q <= nxt_word;
		end
		if (fire) begin
			val_q <= mtg_pkg::temper(fresh);
		end
	end

	assign value_valid = ovalid_q;
	assign value = val_q;

	a_fire_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> state_q == mtg_pkg::ST_RUN)
		else $error("twist outside run state");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= mtg_pkg::LAST_IDX)
		else $error("position out of table");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && !value_ready) |=> value_valid && $stable(value))
		else $error("stalled output word changed");

endmodule

>>> sv/mersenne_twister_generator_top.sv
// mersenne_twister_generator_top: 32-bit twister generator, one word per request
// depends on mtg_pkg, mtg_front, mtg_back, mtg_ram
//
// channel   signals                           kind
// draw      draw_valid, draw_ready, draw      request in, valid/ready transfer
// value     value_valid, value_ready, value   tempered word out, valid/ready
// seed      seed_we, seed_wdata               register write, no wait
//
// one word per cycle sustained while the output is not stalled; a request passes
// through the request count, then the twist and temper into the output register
// after reset and after each seed write the table fill writes all 624 words and then
// passes a prefetch state; requests queue (up to four) but no word comes out meanwhile
// an output stall holds the word; the request queue keeps taking transfers until full
module mersenne_twister_generator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        draw_valid,
	output logic                        draw_ready,
	input  logic                        draw,
	output logic                        value_valid,
	input  logic                        value_ready,
	output logic [mtg_pkg::WORD_W-1:0]  value,
	input  logic                        seed_we,
	input  logic [mtg_pkg::WORD_W-1:0]  seed_wdata
);

	// pending request flag and the back end's take strobe
	logic pend;
	logic take;

	// front end: counts draw transfers that ask for a word
	mtg_front u_front (
		.clk(clk), .arst_n(arst_n),
		.draw_valid(draw_valid), .draw_ready(draw_ready), .draw(draw),
		.pend(pend), .take(take)
	);

	// back end: fill, in-place twist of one word per take, tempering
	mtg_back u_back (
		.clk(clk), .arst_n(arst_n),
		.seed_we(seed_we), .seed_wdata(seed_wdata),
		.pend(pend), .take(take),
		.value_valid(value_valid), .value_ready(value_ready), .value(value)
	);

endmodule

>>> verif/mersenne_twister_generator_top_tb.sv
// mersenne_twister_generator_top_tb: self-checking bench for the twister generator
// depends on mtg_pkg and mersenne_twister_generator_top
module mersenne_twister_generator_top_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 8;

	typedef enum logic [1:0] {
		K_DRAW,
		K_SEED,
		K_DRAIN
	} job_kind_t;

	typedef struct {
		job_kind_t kind;
		logic d;
		logic [mtg_pkg::WORD_W-1:0] data;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic draw_valid = 1'b0;
	logic draw_ready;
	logic draw = 1'b0;
	logic value_valid;
	logic value_ready = 1'b0;
	logic [mtg_pkg::WORD_W-1:0] value;
	logic seed_we = 1'b0;
	logic [mtg_pkg::WORD_W-1:0] seed_wdata = '0;

	job_t jobs[$];
	logic [mtg_pkg::WORD_W-1:0] words_due[$];
	logic [mtg_pkg::WORD_W-1:0] mt_tbl[mtg_pkg::TABLE_WORDS];
	int unsigned mt_pos;
	int errors = 0;
	int quiet = 0;
	int words_seen = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	mersenne_twister_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.draw_valid(draw_valid),
		.draw_ready(draw_ready),
		.draw(draw),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value(value),
		.seed_we(seed_we),
		.seed_wdata(seed_wdata)
	);

	// init recurrence, position parked at the end of the table
	function automatic void mt_reseed(input logic [mtg_pkg::WORD_W-1:0] s);
		logic [mtg_pkg::WORD_W-1:0] p;
		mt_tbl[0] = s;
		for (int k = 1; k < mtg_pkg::TABLE_WORDS; k++) begin
			p = mt_tbl[k-1];
			mt_tbl[k] = mtg_pkg::INIT_MULT * (p ^ (p >> 30)) + mtg_pkg::WORD_W'(k);
		end
		mt_pos = mtg_pkg::TABLE_WORDS;
	endfunction

	// twist the word in place, then temper it
	function automatic logic [mtg_pkg::WORD_W-1:0] mt_next_word();
		int unsigned p, nx, fr;
		logic [mtg_pkg::WORD_W-1:0] mix, y;
		p = (mt_pos >= mtg_pkg::TABLE_WORDS) ? 0 : mt_pos;
		nx = (p + 1) % mtg_pkg::TABLE_WORDS;
		fr = (p + mtg_pkg::SHIFT_OFFSET) % mtg_pkg::TABLE_WORDS;
		mix = {mt_tbl[p][31], mt_tbl[nx][30:0]};
		y = mt_tbl[fr] ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_MATRIX : '0);
		mt_tbl[p] = y;
		mt_pos = p + 1;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic void add_draws(input int n, input bit noise);
		job_t j;
		for (int i = 0; i < n; i++) begin
			j.kind = K_DRAW;
			j.d = noise ? ($urandom_range(0, 19) != 0) : 1'b1;
			j.data = '0;
			jobs.push_back(j);
		end
	endfunction

	// drain first so the write only lands on an idle block
	function automatic void add_seed(input logic [mtg_pkg::WORD_W-1:0] s);
		job_t j;
		j.kind = K_DRAIN;
		j.d = 1'b0;
		j.data = '0;
		jobs.push_back(j);
		j.kind = K_SEED;
		j.data = s;
		jobs.push_back(j);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		int gap;
		logic nv, nd, nwe, took;
		logic [mtg_pkg::WORD_W-1:0] nwd;
		if (!arst_n) begin
			draw_valid <= 1'b0;
			draw <= 1'b0;
			seed_we <= 1'b0;
			seed_wdata <= '0;
			gap = 0;
		end else begin
			nv = draw_valid;
			nd = draw;
			nwe = 1'b0;
			nwd = seed_wdata;
			took = draw_valid && draw_ready;
			if (took && draw) begin
				words_due.push_back(mt_next_word());
			end
			// idle time with nothing in flight, for writes after a no-result transfer
			if (took || words_due.size() != 0) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (took || !draw_valid) begin
				nv = 1'b0;
				if (gap > 0) begin
					gap--;
				end else if (jobs.size() != 0) begin
					case (jobs[0].kind)
						K_DRAW: begin
							nv = 1'b1;
							nd = jobs[0].d;
							void'(jobs.pop_front());
							if (jobs.size() > 150 && $urandom_range(0, 5) == 0) begin
								gap = $urandom_range(1, 4);
							end
						end
						K_DRAIN: begin
							if (words_due.size() == 0 && !took) begin
								void'(jobs.pop_front());
							end
						end
						K_SEED: begin
							if (quiet >= SETTLE) begin
								nwe = 1'b1;
								nwd = jobs[0].data;
								mt_reseed(jobs[0].data);
								void'(jobs.pop_front());
							end
						end
						default: ;
					endcase
				end
			end
			draw_valid <= nv;
			draw <= nd;
			seed_we <= nwe;
			seed_wdata <= nwd;
		end
	end

	// word monitor with its own back-pressure
	always @(posedge clk or negedge arst_n) begin
		int stall, hold;
		if (!arst_n) begin
			value_ready <= 1'b0;
			stall = 0;
			hold = 0;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
			if (value_valid && value_ready) begin
				if (words_due.size() == 0) begin
					$error("value: unexpected word, actual %h", value);
					errors++;
				end else begin
					if (value !== words_due[0]) begin
						$error("value: expected %h actual %h", words_due[0], value);
						errors++;
					end
					void'(words_due.pop_front());
				end
				words_seen++;
				// one long hold-off so the request queue fills and stalls the sender
				if (words_seen == 300) begin
					hold = 80;
				end
			end
			if (hold > 0) begin
				hold--;
			end else if (stall > 0) begin
				stall--;
			end else if (jobs.size() > 150 && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4);
			end
			value_ready <= (hold == 0 && stall == 0);
		end
	end

	initial begin
		mt_reseed(mtg_pkg::RESET_SEED);
		// directed: reset seed, a no-request transfer, the seed extremes
		add_draws(3, 1'b0);
		begin
			job_t j;
			j.kind = K_DRAW;
			j.d = 1'b0;
			j.data = '0;
			jobs.push_back(j);
		end
		add_draws(3, 1'b0);
		add_seed('0);
		add_draws(5, 1'b0);
		add_seed('1);
		add_draws(5, 1'b0);
		// random: long phase runs past the end of the table
		add_seed(mtg_pkg::RESET_SEED);
		add_draws(700, 1'b1);
		add_seed($urandom());
		add_draws(200, 1'b1);
		// sender pause until everything has come back
		add_seed($urandom());
		add_draws(200, 1'b1);
		begin
			job_t j;
			j.kind = K_DRAIN;
			j.d = 1'b0;
			j.data = '0;
			jobs.push_back(j);
		end
		add_draws(200, 1'b1);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (jobs.size() != 0 || draw_valid || words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
